// File: design/dsfa_pkg.sv
// Shared types and constants for the dual sensor frame aligner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dsfa_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned THR_W  = 32;

  localparam logic [THR_W-1:0] THR_RESET = 32'd3000000;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic {
    SENSOR_UP = 1'b0,
    SENSOR_FO = 1'b1
  } sensor_t;

  typedef struct packed {
    logic [ANG_W-1:0] yaw;
    logic [ANG_W-1:0] pitch;
    logic [ANG_W-1:0] roll;
  } pose_t;

  // classified frame as handed from front to back
  typedef struct packed {
    sensor_t           sel;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] ftime;
    pose_t             pose;
    logic [CNT_W-1:0]  up_lost;
    logic [CNT_W-1:0]  fo_lost;
  } frame_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] ftime;
    logic [SEQ_W-1:0]  seq;
    pose_t             pose;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0]  misalign_count;
    logic [CNT_W-1:0]  fo_lost;
    logic [CNT_W-1:0]  up_lost;
    logic [SEQ_W-1:0]  fo_seq;
    logic [SEQ_W-1:0]  up_seq;
    pose_t             fo_pose;
    pose_t             up_pose;
    logic [TIME_W-1:0] pair_time;
  } pair_t;

endpackage

// File: design/dsfa_front.sv
// Front end: per-sensor sequence tracking and lost-frame counting.
// Depends on dsfa_pkg; feeds classified words into dsfa_queue.
`timescale 1ns / 1ps

module dsfa_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  dsfa_pkg::sensor_t          sel,
  input  logic [dsfa_pkg::SEQ_W-1:0] seq,
  input  logic [dsfa_pkg::TIME_W-1:0] ftime,
  input  dsfa_pkg::pose_t            pose,
  output dsfa_pkg::frame_item_t      item
);
  import dsfa_pkg::*;

  logic             seen_up_r, seen_up_nxt, seen_fo_r, seen_fo_nxt;
  logic [SEQ_W-1:0] prev_up_r, prev_up_nxt, prev_fo_r, prev_fo_nxt;
  logic [CNT_W-1:0] lost_up_r, lost_up_nxt, lost_fo_r, lost_fo_nxt;

  logic             seen_c;
  logic [SEQ_W-1:0] prev_c, gap;
  logic [CNT_W-1:0] lost_c, lost_new;

  always_comb begin
    seen_c = (sel == SENSOR_UP) ? seen_up_r : seen_fo_r;
    prev_c = (sel == SENSOR_UP) ? prev_up_r : prev_fo_r;
    lost_c = (sel == SENSOR_UP) ? lost_up_r : lost_fo_r;
    gap    = seq - prev_c - 32'd1;
    // forward jump past prev+1 (wrapping) counts the missing frames
    if (seen_c && (seq > (prev_c + 32'd1))) begin
      lost_new = lost_c + gap;
    end else begin
      lost_new = lost_c;
    end
  end

  always_comb begin
    seen_up_nxt = seen_up_r;
    seen_fo_nxt = seen_fo_r;
    prev_up_nxt = prev_up_r;
    prev_fo_nxt = prev_fo_r;
    lost_up_nxt = lost_up_r;
    lost_fo_nxt = lost_fo_r;
    if (sel == SENSOR_UP) begin
      seen_up_nxt = 1'b1;
      prev_up_nxt = seq;
      lost_up_nxt = lost_new;
    end else begin
      seen_fo_nxt = 1'b1;
      prev_fo_nxt = seq;
      lost_fo_nxt = lost_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_up_r <= 1'b0;
      seen_fo_r <= 1'b0;
      prev_up_r <= '0;
      prev_fo_r <= '0;
      lost_up_r <= '0;
      lost_fo_r <= '0;
    end else if (accept) begin
      seen_up_r <= seen_up_nxt;
      seen_fo_r <= seen_fo_nxt;
      prev_up_r <= prev_up_nxt;
      prev_fo_r <= prev_fo_nxt;
      lost_up_r <= lost_up_nxt;
      lost_fo_r <= lost_fo_nxt;
    end
  end

  always_comb begin
    item.sel     = sel;
    item.seq     = seq;
    item.ftime   = ftime;
    item.pose    = pose;
    item.up_lost = lost_up_nxt;
    item.fo_lost = lost_fo_nxt;
  end

endmodule

// File: design/dsfa_queue.sv
// Short register queue between the front end and the pairing back end.
// Depends on dsfa_pkg for the word type and depth constants.
`timescale 1ns / 1ps

module dsfa_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dsfa_pkg::frame_item_t wdata,
  output logic                  full,
  input  logic                  pop,
  output dsfa_pkg::frame_item_t rdata,
  output logic                  empty
);
  import dsfa_pkg::*;

  frame_item_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/dsfa_back.sv
// Back end: frame slots, overwrite counting, timestamp pairing, output register.
// Depends on dsfa_pkg; drains words from dsfa_queue.
`timescale 1ns / 1ps

module dsfa_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dsfa_pkg::THR_W-1:0] cfg_wdata,
  input  logic                       q_empty,
  input  dsfa_pkg::frame_item_t      q_rdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dsfa_pkg::pair_t            out_pair
);
  import dsfa_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [CNT_W-1:0]  misalign_r, misalign_nxt;
  logic              up_full_r, up_full_nxt, fo_full_r, fo_full_nxt;
  slot_t             slot_up_r, slot_up_nxt, slot_fo_r, slot_fo_nxt;
  logic              out_valid_r;
  pair_t             pair_r, pair_nxt;
  logic              emit;
  logic [TIME_W-1:0] tdiff;
  slot_t             in_slot;

  // output register frees up when empty or being taken
  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_pair  = pair_r;

  always_comb begin
    in_slot.ftime = q_rdata.ftime;
    in_slot.seq   = q_rdata.seq;
    in_slot.pose  = q_rdata.pose;

    slot_up_nxt  = slot_up_r;
    slot_fo_nxt  = slot_fo_r;
    up_full_nxt  = up_full_r;
    fo_full_nxt  = fo_full_r;
    misalign_nxt = misalign_r;
    if (q_rdata.sel == SENSOR_UP) begin
      slot_up_nxt = in_slot;
      up_full_nxt = 1'b1;
      if (up_full_r) begin
        misalign_nxt = misalign_r + 32'd1;
      end
    end else begin
      slot_fo_nxt = in_slot;
      fo_full_nxt = 1'b1;
      if (fo_full_r) begin
        misalign_nxt = misalign_r + 32'd1;
      end
    end

    if (slot_up_nxt.ftime >= slot_fo_nxt.ftime) begin
      tdiff = slot_up_nxt.ftime - slot_fo_nxt.ftime;
    end else begin
      tdiff = slot_fo_nxt.ftime - slot_up_nxt.ftime;
    end
    emit = up_full_nxt && fo_full_nxt && (tdiff <= {{(TIME_W-THR_W){1'b0}}, thr_r});

    pair_nxt.pair_time      = slot_up_nxt.ftime;
    pair_nxt.up_pose        = slot_up_nxt.pose;
    pair_nxt.fo_pose        = slot_fo_nxt.pose;
    pair_nxt.up_seq         = slot_up_nxt.seq;
    pair_nxt.fo_seq         = slot_fo_nxt.seq;
    pair_nxt.up_lost        = q_rdata.up_lost;
    pair_nxt.fo_lost        = q_rdata.fo_lost;
    pair_nxt.misalign_count = misalign_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      misalign_r  <= '0;
      up_full_r   <= 1'b0;
      fo_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        misalign_r  <= misalign_nxt;
        up_full_r   <= up_full_nxt && !emit;
        fo_full_r   <= fo_full_nxt && !emit;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot_up_r <= slot_up_nxt;
      slot_fo_r <= slot_fo_nxt;
      if (emit) begin
        pair_r <= pair_nxt;
      end
    end
  end

endmodule

// File: design/dual_sensor_frame_aligner_core.sv
// Top level of the dual sensor frame aligner.
// Depends on dsfa_pkg, dsfa_front, dsfa_queue and dsfa_back.
//
// Usage:
//   in_*  : stream of parsed pose frames. in_tuser[0] selects the sensor
//           (0 upper, 1 fore); in_tdata carries sequence, timestamp, angles.
//   out_* : stream of fused pairs, one word when both slots hold frames whose
//           timestamps are within the threshold; no word otherwise.
//   cfg_* : cfg_we writes cfg_wdata into the pairing threshold (us).
// Throughput: one frame per cycle sustained while the back end keeps draining
//   (see Stall). The front end tracks sequence gaps in the accept cycle;
//   the back end updates slots and compares timestamps for each queued word.
// Output path: an accepted frame is written into the queue; the back end pops
//   it and, if it completes a pair, loads the output reg that drives out_tvalid.
// Stall: while out_tready is low with a pair pending the back end stops
//   draining; the two-entry queue fills and then in_tready drops.
// Reset: synchronous, active low; clears counters, slots and the queue and
//   loads the threshold with its default of 3000000 us.
`timescale 1ns / 1ps

module dual_sensor_frame_aligner_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] frame_seq, [79:32] frame_time, [111:80] yaw_bits,
  // [143:112] pitch_bits, [175:144] roll_bits
  input  logic [175:0] in_tdata,
  // [0] sensor_sel
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] pair_time, [79:48] up_yaw, [111:80] up_pitch, [143:112] up_roll,
  // [175:144] fo_yaw, [207:176] fo_pitch, [239:208] fo_roll,
  // [271:240] up_seq, [303:272] fo_seq, [335:304] up_lost,
  // [367:336] fo_lost, [399:368] misalign_count
  output logic [399:0] out_tdata,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  import dsfa_pkg::*;

  logic        in_accept;
  logic        q_full, q_empty, q_pop;
  pose_t       in_pose;
  frame_item_t front_item, q_rdata;
  pair_t       pair;
  sensor_t     in_sel;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;
  assign in_sel    = sensor_t'(in_tuser[0]);

  assign in_pose.yaw   = in_tdata[111:80];
  assign in_pose.pitch = in_tdata[143:112];
  assign in_pose.roll  = in_tdata[175:144];

  dsfa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .sel    (in_sel),
    .seq    (in_tdata[31:0]),
    .ftime  (in_tdata[79:32]),
    .pose   (in_pose),
    .item   (front_item)
  );

  dsfa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .wdata (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dsfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pair  (pair)
  );

  assign out_tdata = {pair.misalign_count, pair.fo_lost, pair.up_lost,
                      pair.fo_seq, pair.up_seq,
                      pair.fo_pose.roll, pair.fo_pose.pitch, pair.fo_pose.yaw,
                      pair.up_pose.roll, pair.up_pose.pitch, pair.up_pose.yaw,
                      pair.pair_time};

endmodule
